// File: rtl/core/mwm_pkg.sv
// Shared types and constants for the mecanum wheel mixer.
`timescale 1ns / 1ps
`default_nettype none

package mwm_pkg;

  // Wheel count and datapath widths
  localparam int WHEELS  = 4;
  localparam int SUM_W   = 18;  // wheel sum, signed, up to +-98304
  localparam int MAG_W   = 17;  // wheel magnitude, unsigned
  localparam int LIMIT_W = 15;  // speed limit register
  localparam int QUOT_W  = 15;  // scaled magnitude, never above the limit
  localparam int NUM_W   = MAG_W + LIMIT_W;  // magnitude times limit

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd16384;
  // Divisor used when no scaling applies: num = mag << QUOT_W, so quot = mag
  localparam logic [MAG_W-1:0]   UNITY_DEN   = 17'h08000;

  // Input beat: one body velocity command
  typedef struct packed {
    logic signed [15:0] forward_velocity;
    logic signed [15:0] sideways_velocity;
    logic signed [15:0] rotation_rate;
  } mwm_in_t;

  // Output beat: four wheel current commands
  typedef struct packed {
    logic signed [15:0] front_left_drive;
    logic signed [15:0] front_right_drive;
    logic signed [15:0] rear_left_drive;
    logic signed [15:0] rear_right_drive;
  } mwm_out_t;

  // Mixer front end to divider pipeline
  typedef struct packed {
    logic                               valid;
    logic [WHEELS-1:0]                  neg;
    logic [MAG_W-1:0]                   den;
    logic [WHEELS-1:0][NUM_W-1:0]       num;
  } mwm_div_in_t;

endpackage

`default_nettype wire

// File: rtl/core/mwm_mix.sv
// Mixer front end: wheel sums, magnitudes, peak search and scale setup.
`timescale 1ns / 1ps
`default_nettype none

module mwm_mix import mwm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  mwm_in_t            command,
  input  logic [LIMIT_W-1:0] speed_limit,
  output mwm_div_in_t        div_in
);

  // Stage 1: wheel sums
  logic                                  valid1;
  logic [WHEELS-1:0][SUM_W-1:0]          wheel;
  logic signed [SUM_W-1:0]               vx, vy, wz;

  assign vx = SUM_W'(command.forward_velocity);
  assign vy = SUM_W'(command.sideways_velocity);
  assign wz = SUM_W'(command.rotation_rate);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
    end else begin
      valid1 <= in_valid;
    end
    wheel[0] <= vx - vy - wz;  // front left
    wheel[1] <= vx + vy + wz;  // front right
    wheel[2] <= vx + vy - wz;  // rear left
    wheel[3] <= vx - vy + wz;  // rear right
  end

  // Stage 2: sign and magnitude per wheel
  logic                         valid2;
  logic [WHEELS-1:0]            neg2;
  logic [WHEELS-1:0][MAG_W-1:0] mag2;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid2 <= 1'b0;
    end else begin
      valid2 <= valid1;
    end
    for (int i = 0; i < WHEELS; i++) begin
      neg2[i] <= wheel[i][SUM_W-1];
      mag2[i] <= wheel[i][SUM_W-1] ? MAG_W'(-wheel[i]) : wheel[i][MAG_W-1:0];
    end
  end

  // Stage 3: largest magnitude (two-level compare tree)
  logic                         valid3;
  logic [WHEELS-1:0]            neg3;
  logic [WHEELS-1:0][MAG_W-1:0] mag3;
  logic [MAG_W-1:0]             peak3;
  logic [MAG_W-1:0]             max01, max23;

  assign max01 = (mag2[1] > mag2[0]) ? mag2[1] : mag2[0];
  assign max23 = (mag2[3] > mag2[2]) ? mag2[3] : mag2[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid3 <= 1'b0;
    end else begin
      valid3 <= valid2;
    end
    neg3  <= neg2;
    mag3  <= mag2;
    peak3 <= (max23 > max01) ? max23 : max01;
  end

  // Scale setup: numerator and common divisor, registered in the divider
  logic scale;

  assign scale = peak3 > {{(MAG_W-LIMIT_W){1'b0}}, speed_limit};

  always_comb begin
    div_in.valid = valid3;
    div_in.neg   = neg3;
    div_in.den   = scale ? peak3 : UNITY_DEN;
    for (int i = 0; i < WHEELS; i++) begin
      if (scale) begin
        div_in.num[i] = {{LIMIT_W{1'b0}}, mag3[i]} * {{MAG_W{1'b0}}, speed_limit};
      end else begin
        // No scaling: magnitude is at most the limit, so it fits QUOT_W bits
        div_in.num[i] = {{(NUM_W-2*QUOT_W){1'b0}}, mag3[i][QUOT_W-1:0], {QUOT_W{1'b0}}};
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/mwm_divider.sv
// Four-lane restoring divider, one quotient bit per pipeline stage.
`timescale 1ns / 1ps
`default_nettype none

module mwm_divider import mwm_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  mwm_div_in_t                   div_in,
  output logic                          valid,
  output logic [WHEELS-1:0]             neg,
  output logic [WHEELS-1:0][QUOT_W-1:0] quot
);

  // Per-stage pipeline registers; stage 0 is the input register
  logic                          vld  [0:QUOT_W];
  logic [WHEELS-1:0]             sgn  [0:QUOT_W];
  logic [WHEELS-1:0][QUOT_W-1:0] qt   [0:QUOT_W];
  logic [MAG_W-1:0]              den  [0:QUOT_W-1];
  logic [WHEELS-1:0][MAG_W-1:0]  rem  [0:QUOT_W-1];
  logic [WHEELS-1:0][QUOT_W-1:0] low  [0:QUOT_W-1];

  // Load: upper dividend bits start the remainder (below the divisor)
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= div_in.valid;
    end
    sgn[0] <= div_in.neg;
    den[0] <= div_in.den;
    for (int l = 0; l < WHEELS; l++) begin
      rem[0][l] <= div_in.num[l][NUM_W-1:QUOT_W];
      low[0][l] <= div_in.num[l][QUOT_W-1:0];
      qt[0][l]  <= '0;
    end
  end

  for (genvar k = 0; k < QUOT_W; k++) begin : g_stage
    logic [WHEELS-1:0][MAG_W-1:0]  rem_next;
    logic [WHEELS-1:0][QUOT_W-1:0] low_next;
    logic [WHEELS-1:0]             qbit;

    // Shift in the next dividend bit, subtract if it fits
    for (genvar l = 0; l < WHEELS; l++) begin : g_lane
      logic [MAG_W:0] trial;
      logic [MAG_W:0] diff;
      assign trial       = {rem[k][l], low[k][l][QUOT_W-1]};
      assign diff        = trial - {1'b0, den[k]};
      assign qbit[l]     = trial >= {1'b0, den[k]};
      assign rem_next[l] = qbit[l] ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
      assign low_next[l] = {low[k][l][QUOT_W-2:0], 1'b0};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
      sgn[k+1] <= sgn[k];
      for (int l = 0; l < WHEELS; l++) begin
        qt[k+1][l] <= {qt[k][l][QUOT_W-2:0], qbit[l]};
      end
    end

    // Remainder path ends one stage before the quotient
    if (k < QUOT_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        den[k+1] <= den[k];
        rem[k+1] <= rem_next;
        low[k+1] <= low_next;
      end
    end
  end

  assign valid = vld[QUOT_W];
  assign neg   = sgn[QUOT_W];
  assign quot  = qt[QUOT_W];

endmodule

`default_nettype wire

// File: rtl/core/mecanum_wheel_mixer.sv
// Top level of the mecanum wheel mixer: limit register, mixer, divider, output.
//
// Usage:
//   A command beat (forward, sideways, rotation velocity) is taken at a rising
//   edge with start high and busy low. busy is held low: the block takes one
//   command every cycle, with up to 20 commands in flight.
//   Each command yields one result beat: the four wheel drive commands on
//   result, marked by done for exactly one cycle, in command order.
//   The accepting edge loads mixer stage 1; the command then passes mixer
//   stages 2 and 3, the divider load register, 15 divider stages and one
//   output register, which raises done. Throughput: one command per clock
//   cycle, set by the one-bit-per-stage divider pipeline.
//   When the largest wheel magnitude exceeds speed_limit, every wheel is
//   scaled to trunc(wheel * limit / max), truncated toward zero.
//   speed_limit is written with speed_limit_we / speed_limit_wdata. The user
//   must write it only while no command is in flight; the block has no check.
//   Reset (synchronous, rst high) empties the pipeline, drops done and sets
//   speed_limit to 16384. The receiver cannot stall: each result beat must
//   be taken in the cycle done is high.
`timescale 1ns / 1ps
`default_nettype none

module mecanum_wheel_mixer import mwm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  mwm_in_t            command,
  output logic               done,
  output mwm_out_t           result,
  input  logic               speed_limit_we,
  input  logic [LIMIT_W-1:0] speed_limit_wdata
);

  // Limit register
  logic [LIMIT_W-1:0] speed_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_limit <= LIMIT_RESET;
    end else if (speed_limit_we) begin
      speed_limit <= speed_limit_wdata;
    end
  end

  assign busy = 1'b0;

  // Front end and divider pipeline
  mwm_div_in_t                   div_in;
  logic                          div_valid;
  logic [WHEELS-1:0]             div_neg;
  logic [WHEELS-1:0][QUOT_W-1:0] div_quot;

  mwm_mix u_mix (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (start && !busy),
    .command     (command),
    .speed_limit (speed_limit),
    .div_in      (div_in)
  );

  mwm_divider u_div (
    .clk    (clk),
    .rst    (rst),
    .div_in (div_in),
    .valid  (div_valid),
    .neg    (div_neg),
    .quot   (div_quot)
  );

  // Output register: restore sign
  logic [WHEELS-1:0][15:0] drive;

  always_comb begin
    for (int i = 0; i < WHEELS; i++) begin
      drive[i] = div_neg[i] ? -{1'b0, div_quot[i]} : {1'b0, div_quot[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= div_valid;
    end
    result.front_left_drive  <= drive[0];
    result.front_right_drive <= drive[1];
    result.rear_left_drive   <= drive[2];
    result.rear_right_drive  <= drive[3];
  end

endmodule

`default_nettype wire
